// ----- rtl/core/stable_priority_queue_assert.svh -----
// assertion macros used by the checker file spq_checker.sv
// each macro expands to one labelled concurrent assertion on clk and rst_n
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// consequence checked in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and defaults of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_CHARS_DEF = 8;
    localparam int DATA_W        = 64;
    localparam int WORD_CHARS    = 8;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // outcome codes
    localparam logic [2:0] OUT_INSERTED = 3'd0;
    localparam logic [2:0] OUT_FULL     = 3'd1;
    localparam logic [2:0] OUT_REMOVED  = 3'd2;
    localparam logic [2:0] OUT_EMPTY    = 3'd3;
    localparam logic [2:0] OUT_LISTED   = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] status;
        logic [DATA_W-1:0] age;
    } entry_t;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

// ----- rtl/core/stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded queue sorted by key, equal keys leave in arrival order
// ----------------------------------------------------------------------------
// usage
// - a command beat is taken on a rising edge with start high and busy low
// - command 0 inserts (key, status, age), 1 removes the smallest entry,
//   2 lists every entry in ascending order
// - each result beat shows for one cycle with out_valid high; last marks the
//   final beat of a command and the receiver cannot hold results off
// - insert and remove: one beat, in the cycle after the command; a new command
//   may follow in the very next cycle, so one item per cycle
// - list of n entries: busy stays high while the chain rotates one place per
//   cycle past the head cell and one beat per entry is sent, head first;
//   an empty queue answers with one empty beat in the cycle after
// - insert into a full queue is dropped and reported, payload fields read 0
// - command 3 is taken and ignored
// - reset empties the queue at once and clears all pending results
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int KEY_CHARS = spq_pkg::KEY_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 command,
    input  logic [spq_pkg::DATA_W-1:0] priority_key,
    input  logic [spq_pkg::DATA_W-1:0] status_text,
    input  logic [spq_pkg::DATA_W-1:0] age_text,
    output logic                       out_valid,
    output logic [2:0]                 outcome,
    output logic [spq_pkg::DATA_W-1:0] out_priority,
    output logic [spq_pkg::DATA_W-1:0] out_status,
    output logic [spq_pkg::DATA_W-1:0] out_age,
    output logic                       last
);

    localparam int CW = $clog2(DEPTH + 1);

    // keeps the leading KEY_CHARS characters of the packed key
    localparam logic [spq_pkg::DATA_W-1:0] KeyMask =
        ~((spq_pkg::DATA_W'(1) << (8 * (spq_pkg::WORD_CHARS - KEY_CHARS)))
          - spq_pkg::DATA_W'(1));

    // per-cell taps of the chain
    logic            cell_valid [DEPTH];
    spq_pkg::entry_t cell_data  [DEPTH];
    logic            cell_after [DEPTH];

    spq_pkg::cell_op_t cell_op;
    spq_pkg::entry_t   new_data;
    spq_pkg::entry_t   head_data;

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   left_reg;      // list beats still to send
    logic [CW-1:0]   left_next;

    // result beat register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [2:0]                 outcome_reg;
    logic [2:0]                 outcome_next;
    spq_pkg::entry_t            out_data_reg;
    spq_pkg::entry_t            out_data_next;
    logic                       last_reg;
    logic                       last_next;

    logic accept;
    logic full;
    logic empty;

    assign new_data.key    = priority_key & KeyMask;
    assign new_data.status = status_text;
    assign new_data.age    = age_text;
    assign head_data       = cell_data[0];

    assign busy   = (state_reg == spq_pkg::ST_LIST);
    assign accept = start && !busy;
    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);

    // chain of cells, slot 0 holds the smallest key
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic            l_valid;
            spq_pkg::entry_t l_data;
            logic            l_after;
            logic            r_valid;
            spq_pkg::entry_t r_data;

            if (gi == 0)
            begin : g_first
                assign l_valid = 1'b0;
                assign l_data  = new_data;
                assign l_after = 1'b0;
            end
            else
            begin : g_inner_l
                assign l_valid = cell_valid[gi-1];
                assign l_data  = cell_data[gi-1];
                assign l_after = cell_after[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_data  = head_data;
            end
            else
            begin : g_inner_r
                assign r_valid = cell_valid[gi+1];
                assign r_data  = cell_data[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .new_data    (new_data),
                .left_valid  (l_valid),
                .left_data   (l_data),
                .left_after  (l_after),
                .right_valid (r_valid),
                .right_data  (r_data),
                .head_data   (head_data),
                .valid       (cell_valid[gi]),
                .data        (cell_data[gi]),
                .after       (cell_after[gi])
            );
        end
    endgenerate

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        cell_op        = spq_pkg::CELL_HOLD;
        out_valid_next = 1'b0;
        outcome_next   = outcome_reg;
        out_data_next  = '0;
        last_next      = 1'b1;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        spq_pkg::CMD_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                outcome_next = spq_pkg::OUT_FULL;
                            end
                            else
                            begin
                                cell_op      = spq_pkg::CELL_INSERT;
                                cnt_next     = cnt_reg + CW'(1);
                                outcome_next = spq_pkg::OUT_INSERTED;
                            end
                        end
                        spq_pkg::CMD_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                outcome_next = spq_pkg::OUT_EMPTY;
                            end
                            else
                            begin
                                cell_op       = spq_pkg::CELL_POP;
                                cnt_next      = cnt_reg - CW'(1);
                                outcome_next  = spq_pkg::OUT_REMOVED;
                                out_data_next = head_data;
                            end
                        end
                        spq_pkg::CMD_LIST:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                outcome_next   = spq_pkg::OUT_EMPTY;
                            end
                            else
                            begin
                                state_next = spq_pkg::ST_LIST;
                                left_next  = cnt_reg;
                            end
                        end
                        default:
                        begin
                            state_next = spq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            spq_pkg::ST_LIST:
            begin
                // send the head, then rotate the occupied slots by one
                cell_op        = spq_pkg::CELL_ROTATE;
                out_valid_next = 1'b1;
                outcome_next   = spq_pkg::OUT_LISTED;
                out_data_next  = head_data;
                last_next      = (left_reg == CW'(1));
                left_next      = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg  <= outcome_next;
        out_data_reg <= out_data_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = outcome_reg;
    assign out_priority = out_data_reg.key;
    assign out_status   = out_data_reg.status;
    assign out_age      = out_data_reg.age;
    assign last         = last_reg;

endmodule

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry and trades it with neighbours
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::cell_op_t op,
    input  spq_pkg::entry_t   new_data,
    input  logic              left_valid,
    input  spq_pkg::entry_t   left_data,
    input  logic              left_after,
    input  logic              right_valid,
    input  spq_pkg::entry_t   right_data,
    input  spq_pkg::entry_t   head_data,
    output logic              valid,
    output spq_pkg::entry_t   data,
    output logic              after
);

    logic            valid_reg;
    logic            valid_next;
    spq_pkg::entry_t data_reg;
    spq_pkg::entry_t data_next;

    // this slot lies behind the new key: empty, or strictly larger key
    assign after = !valid_reg || (data_reg.key > new_data.key);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (op)
            spq_pkg::CELL_INSERT:
            begin
                if (after)
                begin
                    if (left_after)
                    begin
                        valid_next = left_valid;
                        data_next  = left_data;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        data_next  = new_data;
                    end
                end
            end
            spq_pkg::CELL_POP:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            spq_pkg::CELL_ROTATE:
            begin
                // last occupied slot wraps round to the head entry
                if (valid_reg)
                begin
                    data_next = right_valid ? right_data : head_data;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- rtl/core/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the stable priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "stable_priority_queue_assert.svh"

module spq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 command,
    input logic                       out_valid,
    input logic [2:0]                 outcome,
    input logic [spq_pkg::DATA_W-1:0] out_priority,
    input logic [spq_pkg::DATA_W-1:0] out_status,
    input logic [spq_pkg::DATA_W-1:0] out_age,
    input logic                       last
);

    // insert answers next cycle with a single inserted or full beat
    `SPQ_ASSERT_NEXT(a_insert_beat, start && !busy && (command == spq_pkg::CMD_INSERT), out_valid && last && ((outcome == spq_pkg::OUT_INSERTED) || (outcome == spq_pkg::OUT_FULL)), "insert beat missing")

    // remove answers next cycle with a single removed or empty beat
    `SPQ_ASSERT_NEXT(a_remove_beat, start && !busy && (command == spq_pkg::CMD_REMOVE), out_valid && last && ((outcome == spq_pkg::OUT_REMOVED) || (outcome == spq_pkg::OUT_EMPTY)), "remove beat missing")

    // the final list beat shows as busy falls
    `SPQ_ASSERT_NOW(a_list_end, $fell(busy), out_valid && last && (outcome == spq_pkg::OUT_LISTED), "list ended without last beat")

    // status-only beats carry no entry
    `SPQ_ASSERT_NOW(a_zero_payload, out_valid && (outcome != spq_pkg::OUT_REMOVED) && (outcome != spq_pkg::OUT_LISTED), (out_priority == '0) && (out_status == '0) && (out_age == '0), "payload on status beat")

    // more list beats to come means the queue is still busy
    `SPQ_ASSERT_NOW(a_list_busy, out_valid && !last, busy, "list beat without busy")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

// ----- tb/tb_stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// self-checking bench for the sorted queue with first-in-first-out ties
// ----------------------------------------------------------------------------
// a short directed table covers the empty, full and tie cases and the extreme
// field values, then about 250 random commands run in grow, shrink and mixed
// phases; every command beat taken by the block updates a private sorted copy
// of the queue, whose answers are held in order and compared field by field
// with each result beat the block shows
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

    localparam int          QDEPTH         = spq_pkg::DEPTH_DEF;
    localparam int          QKEY_CHARS     = spq_pkg::KEY_CHARS_DEF;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          RANDOM_ITEMS   = 250;
    localparam int          CALM_TAIL      = 50;
    localparam int          WATCHDOG_LIMIT = 400;
    localparam int          DRAIN_CYCLES   = 32;
    localparam logic [63:0] ALL_ONES       = {64{1'b1}};
    // the low bytes past the kept characters are dropped on insert
    localparam logic [63:0] KEY_KEEP       = ~(ALL_ONES >> (8 * QKEY_CHARS));

    typedef struct packed {
        logic [2:0]  outcome;
        logic [63:0] pri;
        logic [63:0] status;
        logic [63:0] age;
        logic        last;
    } result_t;

    // one line of the directed table; reps repeats an insert to fill up
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] status;
        logic [63:0] age;
        int unsigned reps;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] command;
    logic [63:0] priority_key;
    logic [63:0] status_text;
    logic [63:0] age_text;
    logic out_valid;
    logic [2:0] outcome;
    logic [63:0] out_priority;
    logic [63:0] out_status;
    logic [63:0] out_age;
    logic last;

    // a typed row swaps its hand-written answer in for the predicted one
    bit      row_typed;
    result_t row_want;

    // private sorted copy of the queue contents
    logic [63:0] held_key [QDEPTH];
    logic [63:0] held_status [QDEPTH];
    logic [63:0] held_age [QDEPTH];
    int          held_count;

    result_t     awaited_beats[$];
    int          mismatches;
    int          quiet_cycles;
    stim_row_t   directed_rows[$];

    stable_priority_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .priority_key (priority_key),
        .status_text  (status_text),
        .age_text     (age_text),
        .out_valid    (out_valid),
        .outcome      (outcome),
        .out_priority (out_priority),
        .out_status   (out_status),
        .out_age      (out_age),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
    begin
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    end
    endtask

    function automatic result_t make_beat(input logic [2:0] oc, input logic [63:0] k,
                                          input logic [63:0] s, input logic [63:0] a,
                                          input logic lst);
        result_t b;
        b.outcome = oc;
        b.pri     = k;
        b.status  = s;
        b.age     = a;
        b.last    = lst;
        return b;
    endfunction

    // insert keeps ascending order and goes behind every equal key, remove pops
    // the head, list walks the whole copy; command 3 leaves everything alone
    task automatic track_queue_command(input logic [1:0] cmd, input logic [63:0] key,
                                       input logic [63:0] st, input logic [63:0] age,
                                       input bit typed, input result_t typed_beat);
        result_t     beats[$];
        logic [63:0] kept;
        int          pos;
        int          i;
    begin
        case (cmd)
            spq_pkg::CMD_INSERT:
            begin
                if (held_count >= QDEPTH)
                    beats.push_back(make_beat(spq_pkg::OUT_FULL, '0, '0, '0, 1'b1));
                else
                begin
                    kept = key & KEY_KEEP;
                    pos  = 0;
                    while (pos < held_count && held_key[pos] <= kept)
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_key[i]    = held_key[i-1];
                        held_status[i] = held_status[i-1];
                        held_age[i]    = held_age[i-1];
                    end
                    held_key[pos]    = kept;
                    held_status[pos] = st;
                    held_age[pos]    = age;
                    held_count++;
                    beats.push_back(make_beat(spq_pkg::OUT_INSERTED, '0, '0, '0, 1'b1));
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (held_count == 0)
                    beats.push_back(make_beat(spq_pkg::OUT_EMPTY, '0, '0, '0, 1'b1));
                else
                begin
                    beats.push_back(make_beat(spq_pkg::OUT_REMOVED, held_key[0],
                                              held_status[0], held_age[0], 1'b1));
                    for (i = 0; i + 1 < held_count; i++)
                    begin
                        held_key[i]    = held_key[i+1];
                        held_status[i] = held_status[i+1];
                        held_age[i]    = held_age[i+1];
                    end
                    held_count--;
                end
            end
            spq_pkg::CMD_LIST:
            begin
                if (held_count == 0)
                    beats.push_back(make_beat(spq_pkg::OUT_EMPTY, '0, '0, '0, 1'b1));
                else
                    for (i = 0; i < held_count; i++)
                        beats.push_back(make_beat(spq_pkg::OUT_LISTED, held_key[i],
                                                  held_status[i], held_age[i],
                                                  i == held_count - 1));
            end
            default:
            begin
                // unused code: no beat, no change
            end
        endcase
        if (typed)
            awaited_beats.push_back(typed_beat);
        else
            foreach (beats[i])
                awaited_beats.push_back(beats[i]);
    end
    endtask

    // ------------------------------------------------------------------------
    // monitor: outputs and the command handshake are sampled at the rising
    // edge, before the driver's nonblocking updates of that edge land
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            // result beats first: a beat taken now always belongs to an older
            // command than one taken at this same edge
            if (out_valid === 1'b1)
            begin
                if (awaited_beats.size() == 0)
                    report_mismatch($sformatf("result beat with nothing awaited, outcome %0d",
                                              outcome));
                else
                begin
                    want = awaited_beats.pop_front();
                    if (outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, wanted %0d",
                                                  outcome, want.outcome));
                    if (out_priority !== want.pri)
                        report_mismatch($sformatf("out_priority %h, wanted %h",
                                                  out_priority, want.pri));
                    if (out_status !== want.status)
                        report_mismatch($sformatf("out_status %h, wanted %h",
                                                  out_status, want.status));
                    if (out_age !== want.age)
                        report_mismatch($sformatf("out_age %h, wanted %h",
                                                  out_age, want.age));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, wanted %b", last, want.last));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                track_queue_command(command, priority_key, status_text, age_text,
                                    row_typed, row_want);
            // watchdog: cycles with neither a command nor a result beat
            if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[stable_priority_queue] ERROR");
                $finish;
            end
        end
    end

    // hold one command until the block takes it; busy is read as it stood
    // just before the edge
    task automatic issue_command(input logic [1:0] cmd, input logic [63:0] key,
                                 input logic [63:0] st, input logic [63:0] age,
                                 input bit typed, input result_t want);
    begin
        start        <= 1'b1;
        command      <= cmd;
        priority_key <= key;
        status_text  <= st;
        age_text     <= age;
        row_typed    <= typed;
        row_want     <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    end
    endtask

    // random source gap, with junk on the fields while start is low
    task automatic maybe_pause(input bit allowed);
        int n;
    begin
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            n            = $urandom_range(1, 16);
            start        <= 1'b0;
            command      <= 2'($urandom_range(0, 3));
            priority_key <= {$urandom, $urandom};
            status_text  <= {$urandom, $urandom};
            age_text     <= {$urandom, $urandom};
            repeat (n) @(posedge clk);
        end
    end
    endtask

    function automatic stim_row_t make_row(input logic [1:0] cmd, input logic [63:0] key,
                                           input logic [63:0] st, input logic [63:0] age,
                                           input int unsigned reps, input bit typed,
                                           input result_t want);
        stim_row_t r;
        r.cmd    = cmd;
        r.key    = key;
        r.status = st;
        r.age    = age;
        r.reps   = reps;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        result_t     none;
        result_t     zero_ins;
        result_t     zero_empty;
        logic [63:0] tie_keys [4];
        logic [63:0] key;
        logic [1:0]  cmd;
        int          pick;
        int          grow_at;
        int          list_at;
        int          k;

        none       = make_beat(spq_pkg::OUT_INSERTED, '0, '0, '0, 1'b0);
        zero_ins   = make_beat(spq_pkg::OUT_INSERTED, '0, '0, '0, 1'b1);
        zero_empty = make_beat(spq_pkg::OUT_EMPTY, '0, '0, '0, 1'b1);

        // every input known from time zero
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= spq_pkg::CMD_INSERT;
        priority_key <= '0;
        status_text  <= '0;
        age_text     <= '0;
        row_typed    <= 1'b0;
        row_want     <= none;
        held_count   = 0;
        mismatches   = 0;
        quiet_cycles = 0;

        // directed table; rows with typed=1 carry their answer by hand
        // empty queue straight out of reset: remove and list both say empty
        directed_rows.push_back(make_row(spq_pkg::CMD_REMOVE, '0, '0, '0, 1, 1,
                                         zero_empty));
        directed_rows.push_back(make_row(spq_pkg::CMD_LIST, '0, '0, '0, 1, 1,
                                         zero_empty));
        // unused code must leave no trace
        directed_rows.push_back(make_row(CMD_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0,
                                         none));
        // extremes round trip through one entry
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, ALL_ONES, ALL_ONES,
                                         ALL_ONES, 1, 1, zero_ins));
        directed_rows.push_back(make_row(spq_pkg::CMD_REMOVE, '0, '0, '0, 1, 1,
                                         make_beat(spq_pkg::OUT_REMOVED,
                                                   ALL_ONES & KEY_KEEP,
                                                   ALL_ONES, ALL_ONES, 1'b1)));
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, '0, '0, '0, 1, 1,
                                         zero_ins));
        directed_rows.push_back(make_row(spq_pkg::CMD_REMOVE, '0, '0, '0, 1, 1,
                                         make_beat(spq_pkg::OUT_REMOVED, '0, '0, '0,
                                                   1'b1)));
        // equal keys must come back in arrival order
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, {"BETA", 32'd0},
                                         {"one", 40'd0}, {"20", 48'd0}, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, {"ALPHA", 24'd0},
                                         {"busy", 32'd0}, {"31", 48'd0}, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, {"BETA", 32'd0},
                                         {"two", 40'd0}, {"42", 48'd0}, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, {"GAMMA", 24'd0},
                                         {"idle", 32'd0}, {"7", 56'd0}, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_LIST, '0, '0, '0, 1, 0, none));
        // fill to the brim, then one more insert is dropped
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, {"BETA", 32'd0},
                                         {"fill", 32'd0}, {"99", 48'd0}, QDEPTH - 4, 0,
                                         none));
        directed_rows.push_back(make_row(spq_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF,
                                         ALL_ONES, ALL_ONES, 1, 1,
                                         make_beat(spq_pkg::OUT_FULL, '0, '0, '0, 1'b1)));
        directed_rows.push_back(make_row(spq_pkg::CMD_LIST, '0, '0, '0, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_REMOVE, '0, '0, '0, 1, 0, none));
        directed_rows.push_back(make_row(spq_pkg::CMD_REMOVE, '0, '0, '0, 1, 0, none));

        // keys that collide often, so ties keep turning up in the random part
        tie_keys[0] = '0;
        tie_keys[1] = ALL_ONES;
        tie_keys[2] = {"MID", 40'd0};
        tie_keys[3] = {"MID", 40'd1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                // repeated rows vary the key a little so the fill mixes ties
                issue_command(directed_rows[r].cmd,
                              directed_rows[r].key ^ (64'(k % 3) << 48),
                              directed_rows[r].status + 64'(k), directed_rows[r].age,
                              directed_rows[r].typed, directed_rows[r].want);
                maybe_pause(1'b1);
            end

        // random part in phases of 25: grow, shrink, mixed, so the queue
        // swings between empty and full; gaps only in alternate stretches
        // of 40 and never in the calm tail
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            case ((k / 25) % 3)
                0:       grow_at = 70;
                1:       grow_at = 25;
                default: grow_at = 45;
            endcase
            list_at = grow_at + (100 - grow_at) * 3 / 4;
            pick    = $urandom_range(0, 99);
            if (pick < grow_at)
                cmd = spq_pkg::CMD_INSERT;
            else if (pick < list_at)
                cmd = spq_pkg::CMD_REMOVE;
            else if (pick < 97)
                cmd = spq_pkg::CMD_LIST;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 1) == 0)
                key = tie_keys[$urandom_range(0, 3)];
            else
                key = {$urandom, $urandom};
            issue_command(cmd, key, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0,
                          none);
            maybe_pause(k < RANDOM_ITEMS - CALM_TAIL && (k / 40) % 2 == 0);
        end
        start <= 1'b0;

        // let every awaited beat arrive, then watch for stray ones
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[stable_priority_queue] OK");
        else
            $display("[stable_priority_queue] ERROR");
        $finish;
    end

endmodule
